### rtl/pqf_pkg.sv
// Shared types, widths and arithmetic helpers for the polar quadratic fit block.
// No dependencies.
package pqf_pkg;

	localparam int IN_FRAC_BITS  = 16;
	localparam int OUT_FRAC_BITS = 32;
	localparam int FO            = IN_FRAC_BITS + OUT_FRAC_BITS;
	localparam int WW            = 130;
	localparam int YW            = 65;
	localparam int DW            = 33;

	typedef logic signed [WW-1:0] wide_t;
	typedef logic signed [YW-1:0] mop_t;
	typedef logic signed [DW-1:0] diff_t;
	typedef logic signed [31:0]   smp_t;
	typedef logic signed [63:0]   coef_t;

	typedef struct packed {
		logic  act;
		smp_t  v1;
		smp_t  v2;
		smp_t  v3;
		smp_t  w1;
		smp_t  w3;
		diff_t d23;
		diff_t d31;
		diff_t d12;
		diff_t dw13;
		diff_t dw23;
		diff_t dw21;
	} item_t;

	typedef struct packed {
		coef_t val;
		logic  ovf;
	} sat_t;

	localparam coef_t COEF_MAX = {1'b0, {63{1'b1}}};
	localparam coef_t COEF_MIN = {1'b1, {63{1'b0}}};

	function automatic wide_t wext32(input smp_t v);
		return {{(WW-32){v[31]}}, v};
	endfunction

	function automatic wide_t wext33(input diff_t v);
		return {{(WW-DW){v[DW-1]}}, v};
	endfunction

	function automatic wide_t wext64(input coef_t v);
		return {{(WW-64){v[63]}}, v};
	endfunction

	function automatic mop_t yext32(input smp_t v);
		return {{(YW-32){v[31]}}, v};
	endfunction

	function automatic mop_t yext33(input diff_t v);
		return {{(YW-DW){v[DW-1]}}, v};
	endfunction

	function automatic mop_t yext64(input coef_t v);
		return {v[63], v};
	endfunction

	function automatic sat_t sat64(input wide_t v);
		sat_t r;
		if ((v[WW-1:63] == '0) || (v[WW-1:63] == '1)) begin
			r.val = v[63:0];
			r.ovf = 1'b0;
		end else begin
			r.val = v[WW-1] ? COEF_MIN : COEF_MAX;
			r.ovf = 1'b1;
		end
		return r;
	endfunction

	// divide by 2^k, rounding toward zero
	function automatic wide_t shr_trunc(input wide_t v, input int unsigned k);
		wide_t m;
		m = (wide_t'(1) <<< k) - wide_t'(1);
		if (v[WW-1])
			return (v + m) >>> k;
		return v >>> k;
	endfunction

endpackage

### rtl/pqf_front.sv
// Front end: accepts fit commands, forms the sample differences, queues up to two items.
// Depends on pqf_pkg.
module pqf_front import pqf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  action,
	input  smp_t  speed_one,
	input  smp_t  speed_two,
	input  smp_t  speed_three,
	input  smp_t  sink_one,
	input  smp_t  sink_two,
	input  smp_t  sink_three,
	output logic  busy,
	output logic  q_valid,
	output item_t q_item,
	input  logic  q_pop
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	item_t      item;

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = mem_q[rd_ptr_q];

	always_comb begin
		item.act  = action;
		item.v1   = speed_one;
		item.v2   = speed_two;
		item.v3   = speed_three;
		item.w1   = sink_one;
		item.w3   = sink_three;
		item.d23  = {speed_two[31], speed_two} - {speed_three[31], speed_three};
		item.d31  = {speed_three[31], speed_three} - {speed_one[31], speed_one};
		item.d12  = {speed_one[31], speed_one} - {speed_two[31], speed_two};
		item.dw13 = {sink_one[31], sink_one} - {sink_three[31], sink_three};
		item.dw23 = {sink_two[31], sink_two} - {sink_three[31], sink_three};
		item.dw21 = {sink_two[31], sink_two} - {sink_one[31], sink_one};
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/pqf_mul.sv
// Bit-serial signed multiplier: wide multiplicand by a 65-bit multiplier, one bit a cycle.
// Depends on pqf_pkg.
module pqf_mul import pqf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  go,
	input  wide_t x,
	input  mop_t  y,
	output logic  done,
	output wide_t p
);

	logic          run_q;
	logic [WW-1:0] acc_q;
	logic [WW-1:0] xs_q;
	logic [YW-1:0] ym_q;
	logic          neg_q;
	logic [WW-1:0] acc_n;
	logic [YW-1:0] ym_n;

	assign acc_n = ym_q[0] ? acc_q + xs_q : acc_q;
	assign ym_n  = ym_q >> 1;

	always_ff @(posedge clk) begin
		if (go) begin
			xs_q  <= x;
			ym_q  <= y[YW-1] ? -y : y;
			neg_q <= y[YW-1];
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_n;
			xs_q  <= xs_q << 1;
			ym_q  <= ym_n;
			if (ym_n == '0)
				p <= neg_q ? -acc_n : acc_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
			end else if (run_q && (ym_n == '0)) begin
				run_q <= 1'b0;
				done  <= 1'b1;
			end
		end
	end

endmodule

### rtl/pqf_div.sv
// Restoring signed divider, truncating, with the quotient saturated to 64 bits.
// Depends on pqf_pkg.
module pqf_div import pqf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  go,
	input  wide_t n,
	input  wide_t d,
	output logic  done,
	output coef_t q,
	output logic  ovf
);

	logic          run_q;
	logic [5:0]    cnt_q;
	logic [WW-1:0] rem_q;
	logic [63:0]   lo_q;
	logic [63:0]   quo_q;
	logic [WW-1:0] dm_q;
	logic          neg_q;
	logic [WW-1:0] nm;
	logic [WW-1:0] dm;
	logic [WW-1:0] hi;
	logic [WW:0]   r2;
	logic          ge;
	logic [63:0]   qf;

	assign nm = n[WW-1] ? -n : n;
	assign dm = d[WW-1] ? -d : d;
	assign hi = WW'(nm[WW-1:64]);
	assign r2 = {rem_q, lo_q[63]};
	assign ge = (r2 >= {1'b0, dm_q});
	assign qf = {quo_q[62:0], ge};

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= hi;
			lo_q  <= nm[63:0];
			dm_q  <= dm;
			neg_q <= n[WW-1] ^ d[WW-1];
			quo_q <= '0;
			if (hi >= dm) begin
				q   <= (n[WW-1] ^ d[WW-1]) ? COEF_MIN : COEF_MAX;
				ovf <= 1'b1;
			end
		end else if (run_q) begin
			rem_q <= ge ? WW'(r2 - {1'b0, dm_q}) : r2[WW-1:0];
			lo_q  <= lo_q << 1;
			quo_q <= qf;
			if (cnt_q == 6'd63) begin
				if (!neg_q) begin
					q   <= qf[63] ? COEF_MAX : qf;
					ovf <= qf[63];
				end else begin
					q   <= (qf > {1'b1, 63'd0}) ? COEF_MIN : -qf;
					ovf <= (qf > {1'b1, 63'd0});
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				cnt_q <= '0;
				if (hi >= dm)
					done <= 1'b1;
				else
					run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

endmodule

### rtl/pqf_back.sv
// Back end: sequences one queued fit through the shared multiplier and divider.
// Depends on pqf_pkg, pqf_mul and pqf_div.
module pqf_back import pqf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_valid,
	input  item_t q_item,
	output logic  q_pop,
	output logic  done,
	output coef_t coef_quad,
	output coef_t coef_lin,
	output coef_t coef_const,
	output logic  fit_valid,
	output logic  degenerate,
	output logic  overflow
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQ1, ST_SQ2, ST_SQ3, ST_DET1, ST_DET2, ST_DET3, ST_NA1, ST_NA2,
		ST_DIVA, ST_MB, ST_DIVB, ST_MC1, ST_MC2, ST_DD, ST_MB2, ST_MC3, ST_FINC
	} state_t;

	state_t state_q;
	logic   ph_q;
	item_t  it_q;
	coef_t  sq1_q;
	coef_t  sq2_q;
	coef_t  sq3_q;
	wide_t  acc_q;
	wide_t  det_q;
	coef_t  a_q;
	coef_t  b_q;
	logic   deg_q;
	logic   ovf_q;

	logic   is_mul;
	logic   mul_go;
	logic   div_go;
	wide_t  mx;
	mop_t   my;
	wide_t  dn;
	wide_t  dd;
	logic   mul_done;
	wide_t  mul_p;
	logic   div_done;
	coef_t  div_q;
	logic   div_ovf;
	sat_t   bsat;
	sat_t   csat;

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	always_comb begin
		case (state_q)
			ST_SQ1, ST_SQ2, ST_SQ3, ST_DET1, ST_DET2, ST_DET3, ST_NA1, ST_NA2,
			ST_MB, ST_MC1, ST_MC2, ST_DD, ST_MB2, ST_MC3: is_mul = 1'b1;
			default:                                     is_mul = 1'b0;
		endcase
	end

	assign mul_go = !ph_q && is_mul && !((state_q == ST_MB) && (it_q.d23 == '0));
	assign div_go = !ph_q && (((state_q == ST_DIVA) && (det_q != '0)) ||
		(state_q == ST_DIVB));

	always_comb begin
		mx = wext32(it_q.v1);
		my = yext32(it_q.v1);
		case (state_q)
			ST_SQ2: begin
				mx = wext32(it_q.v2);
				my = yext32(it_q.v2);
			end
			ST_SQ3: begin
				mx = wext32(it_q.v3);
				my = yext32(it_q.v3);
			end
			ST_DET1: begin
				mx = wext64(sq1_q);
				my = yext33(it_q.d23);
			end
			ST_DET2: begin
				mx = wext64(sq2_q);
				my = yext33(it_q.d31);
			end
			ST_DET3: begin
				mx = wext64(sq3_q);
				my = yext33(it_q.d12);
			end
			ST_NA1: begin
				mx = wext33(it_q.dw13);
				my = yext33(it_q.d23);
			end
			ST_NA2: begin
				mx = wext33(it_q.dw23);
				my = yext33(it_q.d31);
			end
			ST_MB: begin
				mx = wext64(a_q);
				my = yext64(sq2_q) - yext64(sq3_q);
			end
			ST_MC1: begin
				mx = wext64(a_q);
				my = yext64(sq3_q);
			end
			ST_MC2: begin
				mx = wext64(b_q);
				my = yext32(it_q.v3);
			end
			ST_DD: begin
				mx = wext33(it_q.d12);
				my = yext33(it_q.d12);
			end
			ST_MB2: begin
				mx = wext64(a_q);
				my = yext32(it_q.v1);
			end
			ST_MC3: begin
				mx = wext64(a_q);
				my = yext64(sq1_q);
			end
			default: begin
				mx = wext32(it_q.v1);
				my = yext32(it_q.v1);
			end
		endcase
	end

	always_comb begin
		if (state_q == ST_DIVB) begin
			dn = -acc_q;
			dd = wext33(it_q.d23) <<< IN_FRAC_BITS;
		end else begin
			dn = it_q.act ? (wext33(it_q.dw21) <<< FO) : -(acc_q <<< FO);
			dd = det_q;
		end
	end

	assign bsat = sat64(shr_trunc(-(mul_p <<< 1), IN_FRAC_BITS));
	assign csat = sat64(shr_trunc(it_q.act ? acc_q : -acc_q, 2 * IN_FRAC_BITS));

	pqf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.x      (mx),
		.y      (my),
		.done   (mul_done),
		.p      (mul_p)
	);

	pqf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.n      (dn),
		.d      (dd),
		.done   (div_done),
		.q      (div_q),
		.ovf    (div_ovf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			if (mul_go || div_go)
				ph_q <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						it_q    <= q_item;
						deg_q   <= 1'b0;
						ovf_q   <= 1'b0;
						state_q <= ST_SQ1;
					end
				end
				ST_DIVA: begin
					if (!ph_q && (det_q == '0)) begin
						a_q     <= '0;
						deg_q   <= 1'b1;
						state_q <= it_q.act ? ST_MB2 : ST_MB;
					end else if (ph_q && div_done) begin
						a_q     <= div_q;
						ovf_q   <= ovf_q | div_ovf;
						ph_q    <= 1'b0;
						state_q <= it_q.act ? ST_MB2 : ST_MB;
					end
				end
				ST_DIVB: begin
					if (ph_q && div_done) begin
						b_q     <= div_q;
						ovf_q   <= ovf_q | div_ovf;
						ph_q    <= 1'b0;
						state_q <= ST_MC1;
					end
				end
				ST_FINC: begin
					coef_quad  <= a_q;
					coef_lin   <= b_q;
					coef_const <= csat.val;
					fit_valid  <= (a_q > 0) && (b_q < 0) && (csat.val > 0);
					degenerate <= deg_q;
					overflow   <= ovf_q | csat.ovf;
					done       <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: begin
					if (!ph_q && (state_q == ST_MB) && (it_q.d23 == '0)) begin
						b_q     <= '0;
						deg_q   <= 1'b1;
						state_q <= ST_MC1;
					end else if (ph_q && mul_done) begin
						ph_q <= 1'b0;
						case (state_q)
							ST_SQ1: begin
								sq1_q   <= mul_p[63:0];
								state_q <= it_q.act ? ST_DD : ST_SQ2;
							end
							ST_SQ2: begin
								sq2_q   <= mul_p[63:0];
								state_q <= ST_SQ3;
							end
							ST_SQ3: begin
								sq3_q   <= mul_p[63:0];
								state_q <= ST_DET1;
							end
							ST_DET1: begin
								acc_q   <= mul_p;
								state_q <= ST_DET2;
							end
							ST_DET2: begin
								acc_q   <= acc_q + mul_p;
								state_q <= ST_DET3;
							end
							ST_DET3: begin
								det_q   <= acc_q + mul_p;
								state_q <= ST_NA1;
							end
							ST_NA1: begin
								acc_q   <= mul_p;
								state_q <= ST_NA2;
							end
							ST_NA2: begin
								acc_q   <= acc_q + mul_p;
								state_q <= ST_DIVA;
							end
							ST_DD: begin
								det_q   <= mul_p;
								state_q <= ST_DIVA;
							end
							ST_MB: begin
								acc_q   <= mul_p + (wext33(it_q.dw23) <<< FO);
								state_q <= ST_DIVB;
							end
							ST_MC1: begin
								acc_q   <= mul_p + (wext32(it_q.w3) <<< FO);
								state_q <= ST_MC2;
							end
							ST_MC2: begin
								acc_q   <= acc_q + (mul_p <<< IN_FRAC_BITS);
								state_q <= ST_FINC;
							end
							ST_MB2: begin
								b_q     <= bsat.val;
								ovf_q   <= ovf_q | bsat.ovf;
								state_q <= ST_MC3;
							end
							ST_MC3: begin
								acc_q   <= mul_p + (wext32(it_q.w1) <<< FO);
								state_q <= ST_FINC;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
			endcase
		end
	end

endmodule

### rtl/polar_quadratic_fit.sv
// Top level of the polar quadratic fit block: front queue and sequenced back end.
// Depends on pqf_pkg, pqf_front and pqf_back.
//
// Usage:
//   A command beat is taken at a rising edge with start high and busy low:
//   action selects three-point (0) or two-point (1) fitting, the six
//   speed and sink samples are signed Q16.16.
//   Each command gives one result beat: done is high for exactly one cycle
//   with coef_quad, coef_lin, coef_const (signed Q32.32, saturated) and the
//   fit_valid, degenerate and overflow flags.
//   The front holds up to two commands; busy is high while both slots are
//   full. Results come back in command order.
//   The back end works on one fit at a time; the front can take further
//   commands while a fit is in progress. A product takes longer the more
//   significant bits the multiplier operand has; a divide ends early when
//   the quotient overflows or the divisor is zero.
//   Reset clears the queue and the sequencer; no result is pending after it.
//   The receiver cannot stall: every result must be taken in its cycle.
module polar_quadratic_fit import pqf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  logic  action,
	input  smp_t  speed_one,
	input  smp_t  speed_two,
	input  smp_t  speed_three,
	input  smp_t  sink_one,
	input  smp_t  sink_two,
	input  smp_t  sink_three,
	output logic  done,
	output coef_t coef_quad,
	output coef_t coef_lin,
	output coef_t coef_const,
	output logic  fit_valid,
	output logic  degenerate,
	output logic  overflow
);

	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	pqf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (action),
		.speed_one   (speed_one),
		.speed_two   (speed_two),
		.speed_three (speed_three),
		.sink_one    (sink_one),
		.sink_two    (sink_two),
		.sink_three  (sink_three),
		.busy        (busy),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	pqf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.done       (done),
		.coef_quad  (coef_quad),
		.coef_lin   (coef_lin),
		.coef_const (coef_const),
		.fit_valid  (fit_valid),
		.degenerate (degenerate),
		.overflow   (overflow)
	);

endmodule

### rtl/pqf_checker.sv
// Port-level checks for polar_quadratic_fit, bound to the top level.
// Depends on pqf_pkg.
module pqf_checker import pqf_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  start,
	input logic  busy,
	input logic  done,
	input coef_t coef_quad,
	input coef_t coef_lin,
	input coef_t coef_const,
	input logic  fit_valid
);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beats back to back");

	a_valid_signs: assert property (@(posedge clk) disable iff (!arst_n)
		done && fit_valid |-> (coef_quad > 0) && (coef_lin < 0) && (coef_const > 0))
		else $error("fit_valid with wrong coefficient signs");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command beat");

endmodule

bind polar_quadratic_fit pqf_checker u_pqf_checker (.*);
